// ===== hw/rtl/url_percent_decode_assert.svh =====
// ----------------------------------------------------------------------------
// url_percent_decode assertion macros
// Short forms for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef URL_PERCENT_DECODE_ASSERT_SVH
`define URL_PERCENT_DECODE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder package
// Beat types, character codes, rule flag positions and decode helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

	// Input beat: one byte of the escaped string.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_beat_t;

	// Output beat: one byte of the decoded string.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_end;
	} out_beat_t;

	// What is held between input bytes.
	typedef enum logic [1:0] {
		PEND_NONE  = 2'd0,
		PEND_PCT   = 2'd1,
		PEND_DIGIT = 2'd2
	} pend_t;

	localparam int RULE_W = 5;
	localparam logic [RULE_W-1:0] RULE_RESET = 5'd1;

	// Rule flag bit positions.
	localparam int RULE_SPACE   = 1;
	localparam int RULE_SPECIAL = 2;
	localparam int RULE_CONTROL = 3;
	localparam int RULE_PLUS    = 4;

	localparam logic [7:0] CHAR_PERCENT = 8'h25;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_HIGH    = 8'h80;

	// Decoded bytes below 0x80 that are always released, one bit per code.
	localparam logic [127:0] ALLOW_TABLE = 128'h7FFF_FFFF_FFFF_FFFF_5FFF_F796_0000_0000;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
		end
		return t[3:0];
	endfunction

	// Whether a decoded byte may be released under the given rules.
	function automatic logic allowed(input logic [7:0] v, input logic [RULE_W-1:0] r);
		return v[7] || ALLOW_TABLE[v[6:0]] ||
			(v == CHAR_SPACE && r[RULE_SPACE]) ||
			(v > CHAR_SPACE && v < CHAR_HIGH && r[RULE_SPECIAL]) ||
			(v < CHAR_SPACE && r[RULE_CONTROL]);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/url_percent_decode.sv =====
// URL percent decoder. Bytes of an escaped string enter one beat per cycle on
// the input channel while in_ready is high; decoded bytes leave on the output
// channel, with run_last on the final byte caused by each input beat and
// string_end on the final byte of the string. An input beat yields zero to
// three output beats, and those leave one per cycle while out_ready is high
// from a three-entry result register, so the block takes one byte per cycle
// while every byte yields at most one result and the output is not stalled.
// A byte passes the input register, then the result register, before its
// first result is on the output port. cfg_data is written on its own channel;
// the user must write it only while idle, the block itself does not enforce it.
// ----------------------------------------------------------------------------
// URL percent decoder, top level
// Input register, single-pass escape decode and a draining result register.
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_decode (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire upd_pkg::in_beat_t     in_data,
	output logic                       out_valid,
	input  wire                        out_ready,
	output upd_pkg::out_beat_t         out_data,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire [upd_pkg::RULE_W-1:0]  cfg_data
);

	logic [upd_pkg::RULE_W-1:0] rule_q;
	logic                       valid_s1;
	upd_pkg::in_beat_t          data_s1;
	upd_pkg::pend_t             pend_q;
	logic [7:0]                 first_q;
	logic [7:0]                 res_q [3];
	logic [1:0]                 rem_q;
	logic [1:0]                 idx_q;
	logic                       end_q;

	logic                       res_free;
	logic                       adv;
	logic                       out_fire;

	// Decode results
	logic [7:0]                 slot [3];
	logic [1:0]                 res_n;
	upd_pkg::pend_t             nxt_pend;
	logic                       load_first;

	// Handshake: the result register takes a new item once it is empty or
	// its last beat leaves in this cycle.
	assign cfg_ready = 1'b1;
	assign out_fire  = out_valid && out_ready;
	assign res_free  = (rem_q == 2'd0) || (rem_q == 2'd1 && out_ready);
	assign adv       = valid_s1 && res_free;
	assign in_ready  = !valid_s1 || res_free;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q <= upd_pkg::RULE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			rule_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	// Escape decode: up to two held bytes ('%' and a first digit) followed by
	// at most one byte for the current input.
	always_comb begin
		logic [7:0] b;
		logic       last;
		logic [7:0] plain_b;
		logic       f_n;
		logic [7:0] f_byte;
		upd_pkg::pend_t f_pend;
		logic [1:0] pre_n;
		logic       tail_n;
		logic [7:0] tail_b;
		logic [7:0] v;

		b      = data_s1.in_byte;
		last   = data_s1.in_last;
		v      = {upd_pkg::hex_val(first_q), upd_pkg::hex_val(b)};

		plain_b = (rule_q[upd_pkg::RULE_PLUS] && b == upd_pkg::CHAR_PLUS) ?
			upd_pkg::CHAR_SPACE : b;

		// A byte taken as fresh input: a '%' is held unless the string ends.
		f_pend = upd_pkg::PEND_NONE;
		f_n    = 1'b1;
		f_byte = plain_b;
		if (b == upd_pkg::CHAR_PERCENT) begin
			f_byte = upd_pkg::CHAR_PERCENT;
			if (!last) begin
				f_n    = 1'b0;
				f_pend = upd_pkg::PEND_PCT;
			end
		end

		pre_n      = 2'd0;
		tail_n     = f_n;
		tail_b     = f_byte;
		nxt_pend   = f_pend;
		load_first = 1'b0;

		if (rule_q == '0) begin
			// Passthrough: flush what is held, then the byte unchanged.
			tail_n   = 1'b1;
			tail_b   = b;
			nxt_pend = upd_pkg::PEND_NONE;
			case (pend_q)
				upd_pkg::PEND_PCT:   pre_n = 2'd1;
				upd_pkg::PEND_DIGIT: pre_n = 2'd2;
				default:             pre_n = 2'd0;
			endcase
		end else begin
			case (pend_q)
				upd_pkg::PEND_PCT: begin
					if (!last && upd_pkg::is_hex(b)) begin
						tail_n     = 1'b0;
						nxt_pend   = upd_pkg::PEND_DIGIT;
						load_first = 1'b1;
					end else begin
						pre_n = 2'd1;
					end
				end
				upd_pkg::PEND_DIGIT: begin
					if (upd_pkg::is_hex(b) && upd_pkg::allowed(v, rule_q)) begin
						tail_n   = 1'b1;
						tail_b   = v;
						nxt_pend = upd_pkg::PEND_NONE;
					end else begin
						pre_n = 2'd2;
					end
				end
				default: begin
					pre_n = 2'd0;
				end
			endcase
		end

		if (last) begin
			nxt_pend = upd_pkg::PEND_NONE;
		end

		slot[0] = (pre_n != 2'd0) ? upd_pkg::CHAR_PERCENT : tail_b;
		slot[1] = (pre_n == 2'd2) ? first_q : tail_b;
		slot[2] = tail_b;
		res_n   = pre_n + {1'b0, tail_n};
	end

	// Held escape state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= upd_pkg::PEND_NONE;
			first_q <= 8'h00;
		end else if (adv) begin
			pend_q <= nxt_pend;
			if (load_first) begin
				first_q <= data_s1.in_byte;
			end
		end
	end

	// Result register control: loaded with a whole item, drained a beat at
	// a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (adv) begin
			rem_q <= res_n;
			idx_q <= 2'd0;
		end else if (out_fire) begin
			rem_q <= rem_q - 2'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q[0] <= slot[0];
			res_q[1] <= slot[1];
			res_q[2] <= slot[2];
			end_q    <= data_s1.in_last;
		end
	end

	// Output beat.
	assign out_valid           = (rem_q != 2'd0);
	assign out_data.out_byte   = res_q[idx_q];
	assign out_data.run_last   = (rem_q == 2'd1);
	assign out_data.string_end = (rem_q == 2'd1) && end_q;

endmodule

`default_nettype wire

// ===== hw/rtl/upd_checker.sv =====
// ----------------------------------------------------------------------------
// URL percent decoder port checker
// Watches the top-level ports over time; bound to every decoder instance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "url_percent_decode_assert.svh"

module upd_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_ready,
	input wire upd_pkg::in_beat_t     in_data,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire upd_pkg::out_beat_t    out_data,
	input wire                        cfg_valid,
	input wire                        cfg_ready
);

	// A stalled input beat holds.
	`UPD_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data), "input beat changed while stalled")

	// A stalled output beat holds.
	`UPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output beat changed while stalled")

	// The end of the string is always the final beat of its input byte.
	`UPD_ASSERT_NOW(a_end_is_run_last, out_valid && out_data.string_end, out_data.run_last, "string_end without run_last")

	// A run that is not finished continues in the next cycle.
	`UPD_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !out_data.run_last, out_valid, "run of results broken off")

	// Configuration writes are never stalled.
	`UPD_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind url_percent_decode upd_checker u_upd_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder testbench
// Sends escaped strings through url_percent_decode under a range of rule
// settings and compares every decoded beat with a byte-level prediction.
// Both channels stall at random, apart from one phase that runs without stalls.
// ----------------------------------------------------------------------------

module testbench;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	upd_pkg::in_beat_t          in_data = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	upd_pkg::out_beat_t         out_data;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [upd_pkg::RULE_W-1:0] cfg_data = upd_pkg::RULE_RESET;

	// Predictor state: the rules in force, what is held, and the held digit.
	logic [upd_pkg::RULE_W-1:0] rules_m = upd_pkg::RULE_RESET;
	upd_pkg::pend_t             pend_m = upd_pkg::PEND_NONE;
	logic [7:0]                 digit_m = 8'h00;

	upd_pkg::in_beat_t          beat_q [$];
	upd_pkg::out_beat_t         decoded_q [$];
	logic [7:0]                 run_bytes [$];

	int                         beats_issued = 0;
	int                         beats_taken = 0;
	int                         bytes_checked = 0;
	int                         total_beats = 0;
	int                         errors = 0;
	bit                         calm = 1'b0;

	url_percent_decode u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 12 ns clock.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic bit hex_digit(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
	endfunction

	// Value of a character already known to be a hex digit.
	function automatic logic [3:0] nibble(input logic [7:0] c);
		logic [7:0] t;
		if (c <= "9") begin
			t = c - 8'h30;
		end else if (c <= "F") begin
			t = c - 8'h37;
		end else begin
			t = c - 8'h57;
		end
		return t[3:0];
	endfunction

	// Decoded bytes below 0x80 that are released whatever the rules say.
	function automatic bit always_released(input logic [6:0] v);
		case (v)
			7'h23, 7'h25, 7'h26, 7'h2B, 7'h3D, 7'h3F, 7'h7F: return 1'b0;
			default: return v > 7'h20;
		endcase
	endfunction

	function automatic bit release_ok(input logic [7:0] v);
		return v[7] || always_released(v[6:0]) ||
			(v == upd_pkg::CHAR_SPACE && rules_m[upd_pkg::RULE_SPACE]) ||
			(v > upd_pkg::CHAR_SPACE && rules_m[upd_pkg::RULE_SPECIAL]) ||
			(v < upd_pkg::CHAR_SPACE && rules_m[upd_pkg::RULE_CONTROL]);
	endfunction

	task automatic emit_plain(input logic [7:0] c);
		if (rules_m[upd_pkg::RULE_PLUS] && c == upd_pkg::CHAR_PLUS) begin
			run_bytes.insert(run_bytes.size(), upd_pkg::CHAR_SPACE);
		end else begin
			run_bytes.insert(run_bytes.size(), c);
		end
	endtask

	// A byte seen afresh: a percent starts an escape unless the string ends here.
	task automatic emit_fresh(input logic [7:0] c, input bit last);
		if (c == upd_pkg::CHAR_PERCENT) begin
			if (last) begin
				run_bytes.insert(run_bytes.size(), upd_pkg::CHAR_PERCENT);
			end else begin
				pend_m = upd_pkg::PEND_PCT;
			end
		end else begin
			emit_plain(c);
		end
	endtask

	// Works out the decoded beats that one input beat causes.
	task automatic decode_beat(input upd_pkg::in_beat_t b);
		upd_pkg::pend_t     held;
		logic [7:0]         v;
		upd_pkg::out_beat_t r;
		held = pend_m;
		pend_m = upd_pkg::PEND_NONE;
		run_bytes.delete();
		v = {nibble(digit_m), nibble(b.in_byte)};
		if (rules_m == '0) begin
			if (held == upd_pkg::PEND_PCT || held == upd_pkg::PEND_DIGIT) begin
				run_bytes.insert(run_bytes.size(), upd_pkg::CHAR_PERCENT);
			end
			if (held == upd_pkg::PEND_DIGIT) begin
				run_bytes.insert(run_bytes.size(), digit_m);
			end
			run_bytes.insert(run_bytes.size(), b.in_byte);
		end else if (held == upd_pkg::PEND_PCT) begin
			if (!b.in_last && hex_digit(b.in_byte)) begin
				digit_m = b.in_byte;
				pend_m = upd_pkg::PEND_DIGIT;
			end else begin
				run_bytes.insert(run_bytes.size(), upd_pkg::CHAR_PERCENT);
				emit_fresh(b.in_byte, b.in_last);
			end
		end else if (held == upd_pkg::PEND_DIGIT) begin
			if (hex_digit(b.in_byte) && release_ok(v)) begin
				run_bytes.insert(run_bytes.size(), v);
			end else begin
				run_bytes.insert(run_bytes.size(), upd_pkg::CHAR_PERCENT);
				run_bytes.insert(run_bytes.size(), digit_m);
				emit_fresh(b.in_byte, b.in_last);
			end
		end else begin
			emit_fresh(b.in_byte, b.in_last);
		end
		if (b.in_last) begin
			pend_m = upd_pkg::PEND_NONE;
		end
		foreach (run_bytes[i]) begin
			r.out_byte = run_bytes[i];
			r.run_last = (i == run_bytes.size() - 1);
			r.string_end = r.run_last && b.in_last;
			decoded_q.insert(decoded_q.size(), r);
		end
	endtask

	// Driver: new beats and ready change on the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			out_ready <= calm || ($urandom_range(99) >= 10);
			if (beats_taken == beats_issued) begin
				if (beat_q.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
					in_data <= beat_q.pop_front();
					in_valid <= 1'b1;
					beats_issued++;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: predict on each accepted input beat, check each output beat.
	always @(posedge clk) begin
		upd_pkg::out_beat_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				decode_beat(in_data);
				beats_taken++;
			end
			if (out_valid && out_ready) begin
				bytes_checked++;
				if (decoded_q.size() == 0) begin
					errors++;
					$display("t=%0t: unexpected beat, expected none, %s %h last %b end %b",
						$time, "got byte", out_data.out_byte, out_data.run_last,
						out_data.string_end);
				end else begin
					want = decoded_q.pop_front();
					if (out_data.out_byte !== want.out_byte ||
						out_data.run_last !== want.run_last ||
						out_data.string_end !== want.string_end) begin
						errors++;
						$display("t=%0t: mismatch, expected byte %h last %b end %b, %s",
							$time, want.out_byte, want.run_last, want.string_end,
							"got the following");
						$display("t=%0t:   got byte %h last %b end %b",
							$time, out_data.out_byte, out_data.run_last,
							out_data.string_end);
					end
				end
			end
		end
	end

	task automatic add_byte(input logic [7:0] c, input bit last);
		upd_pkg::in_beat_t b;
		b.in_byte = c;
		b.in_last = last;
		beat_q.insert(beat_q.size(), b);
		total_beats++;
	endtask

	task automatic add_text(input string s, input bit close);
		for (int i = 0; i < s.len(); i++) begin
			add_byte(s[i], close && (i == s.len() - 1));
		end
	endtask

	// Hex digit for a nibble, upper or lower case at random.
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return 8'h30 + n;
		end
		return ($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10;
	endfunction

	// Random string: mostly well-formed escapes, with plus signs, stray
	// percents, broken escapes and raw bytes mixed in.
	task automatic add_string(input int len, input bit close);
		int         roll;
		bit         fin;
		logic [7:0] v;
		for (int k = 0; k < len; k++) begin
			roll = $urandom_range(99);
			fin = close && (k == len - 1);
			v = 8'($urandom_range(255));
			if (roll < 40) begin
				add_byte(upd_pkg::CHAR_PERCENT, 1'b0);
				add_byte(hex_char(v[7:4]), 1'b0);
				add_byte(hex_char(v[3:0]), fin);
			end else if (roll < 50) begin
				add_byte(upd_pkg::CHAR_PERCENT, 1'b0);
				if ($urandom_range(1)) begin
					add_byte(hex_char(v[3:0]), 1'b0);
				end
				add_byte(8'($urandom_range(255)), fin);
			end else if (roll < 62) begin
				add_byte(upd_pkg::CHAR_PLUS, fin);
			end else if (roll < 70) begin
				add_byte(upd_pkg::CHAR_PERCENT, fin);
			end else begin
				add_byte(v, fin);
			end
		end
	endtask

	// Waits until every beat has gone in and every decoded beat has come out,
	// then lets the pipeline settle.
	task automatic drain_results();
		int waited;
		waited = 0;
		while ((beat_q.size() != 0 || beats_taken != beats_issued || decoded_q.size() != 0)
			&& waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic write_rules(input logic [upd_pkg::RULE_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		rules_m = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stimulus: directed strings first, then random phases under several rule settings.
	initial begin
		logic [upd_pkg::RULE_W-1:0] phase_rules [8];
		int                         target;
		phase_rules = '{5'd31, 5'd0, 5'd0, 5'd1, 5'd0, 5'd14, 5'd0, 5'd16};
		phase_rules[2] = 5'($urandom_range(31));
		phase_rules[4] = 5'($urandom_range(31));
		phase_rules[6] = 5'($urandom_range(31));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset rules: a released escape, a rejected one, a high byte, double
		// percent, raw extremes, an escape cut short and a lone final percent.
		add_text("%41%20%fF%%z", 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b1);
		add_text("%A", 1'b1);
		add_text("%", 1'b1);
		// Leave a percent and a digit held, then clear the rules before the next byte.
		add_text("%3", 1'b0);
		drain_results();
		write_rules(5'd0);
		add_text("x", 1'b1);
		drain_results();
		write_rules(5'd31);
		add_text("%20+%0a", 1'b1);
		drain_results();

		for (int p = 0; p < 8; p++) begin
			calm = (p == 3);
			write_rules(phase_rules[p]);
			target = total_beats + 50;
			if (p == 5) begin
				// Hold the sender mid-string until the output has caught up.
				add_string(6, 1'b0);
				drain_results();
			end
			while (total_beats < target) begin
				add_string($urandom_range(1, 12), 1'b1);
			end
			drain_results();
		end
		calm = 1'b0;

		if (decoded_q.size() != 0) begin
			errors += decoded_q.size();
			$display("t=%0t: %0d decoded beats never arrived", $time, decoded_q.size());
		end
		$display("Sent %0d escaped bytes and checked %0d decoded beats", total_beats, bytes_checked);
		$display("under eleven rule settings, including all flags clear and all flags set.");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#5_000_000;
		$display("Run timed out at t=%0t", $time);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
